/* sv/mno_pkg.sv */
// Shared types, constants and helpers for the mask neighbour overlay unit.
// Depends on nothing; every other file imports it.
package mno_pkg;

  // Frame size limits and the coordinate widths that follow from them
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_MINIMUM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_BLUE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_GREEN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_RED         = 3'd6;

  // Register reset values
  localparam int RST_IMAGE_WIDTH  = 640;
  localparam int RST_IMAGE_HEIGHT = 480;
  localparam logic [7:0] RST_CLOSE_LIMIT      = 8'd5;
  localparam logic [3:0] RST_NEIGHBOR_MINIMUM = 4'd3;
  localparam logic [7:0] RST_MARK_BLUE        = 8'd145;
  localparam logic [7:0] RST_MARK_GREEN       = 8'd12;
  localparam logic [7:0] RST_MARK_RED         = 8'd255;

  // Item kinds on the input channel
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Control that travels with one window step
  typedef struct packed {
    logic emit;      // this step releases a result
    logic top_ok;    // neighbour row above lies inside the image
    logic bot_ok;    // neighbour row below lies inside the image
    logic left_ok;   // neighbour column to the left lies inside the image
    logic right_ok;  // neighbour column to the right lies inside the image
    logic fend;      // last result of the frame
  } step_meta_t;

  // One result item
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       marked;
    logic       fend;
  } result_t;

  // Last column index of a frame; zero acts as one, oversize as the maximum
  function automatic logic [COL_W-1:0] width_last(input logic [CFG_DATA_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_DATA_W'(MAX_WIDTH)) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(v - CFG_DATA_W'(1));
    end
    return r;
  endfunction

  // Last row index of a frame; zero acts as one, oversize as the maximum
  function automatic logic [ROW_W-1:0] height_last(input logic [CFG_DATA_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_DATA_W'(MAX_HEIGHT)) begin
      r = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      r = ROW_W'(v - CFG_DATA_W'(1));
    end
    return r;
  endfunction

  // Number of set bits in a nine-bit neighbour vector
  function automatic logic [3:0] count_ones9(input logic [8:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

/* sv/mno_front.sv */
// Input sequencer: raster counters, flush handling and output position tracking.
// Depends on mno_pkg; feeds mno_line_store with one window step per transfer.
module mno_front
  import mno_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [COL_W-1:0] width_last,
  input  logic [ROW_W-1:0] height_last,
  input  logic             size_wr,
  output logic             step_vld,
  output logic [COL_W-1:0] step_col,
  output logic             step_par,
  output step_meta_t       step_meta
);

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic             par_r, par_nxt;
  logic             done_r, done_nxt;
  logic             inject_r, inject_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic acc;
  logic real_px;
  logic col_end;
  logic out_col_end;
  logic out_row_end;
  logic past_first;

  // Hold the input while the output side is full or a spare step is injected
  assign in_stall = ~advance | inject_r;
  assign step_col = in_col_r;
  assign step_par = par_r;

  always_comb begin
    acc         = in_valid & ~in_stall;
    real_px     = acc & ~done_r & (in_kind == KIND_PIXEL);
    col_end     = (in_col_r == width_last);
    out_col_end = (out_col_r == width_last);
    out_row_end = (out_row_r == height_last);
    past_first  = (in_row_r > ROW_W'(1)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));

    // A step is a real pixel, a drain step after the last pixel, or a spare step
    step_vld = (advance & inject_r) | (acc & done_r) | real_px;

    step_meta.emit     = (acc & done_r) | (real_px & past_first);
    step_meta.top_ok   = (out_row_r != '0);
    step_meta.bot_ok   = ~out_row_end;
    step_meta.left_ok  = (out_col_r != '0);
    step_meta.right_ok = ~out_col_end;
    step_meta.fend     = out_col_end & out_row_end;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    par_nxt     = par_r;
    done_nxt    = done_r;
    inject_nxt  = inject_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;

    // Advance the raster position of the window front
    if (step_vld) begin
      if (col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
        par_nxt    = ~par_r;
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end

    // Last pixel: switch to draining; a single-row frame needs one spare step
    if (real_px && col_end && (in_row_r == height_last)) begin
      done_nxt   = 1'b1;
      inject_nxt = (height_last == '0);
    end

    if (advance && inject_r) begin
      inject_nxt = 1'b0;
    end

    // Track the output position; the frame closes on its last result
    if (step_meta.emit) begin
      if (step_meta.fend) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        par_nxt     = 1'b0;
        done_nxt    = 1'b0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end

    // A new frame size drops the frame in progress
    if (size_wr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      par_nxt     = 1'b0;
      done_nxt    = 1'b0;
      inject_nxt  = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      par_r     <= 1'b0;
      done_r    <= 1'b0;
      inject_r  <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      par_r     <= par_nxt;
      done_r    <= done_nxt;
      inject_r  <= inject_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

/* sv/mno_line_store.sv */
// Line memories for mask and colour, plus the 3x3 mask window and colour delay.
// Depends on mno_pkg; driven by mno_front, read by mno_decide.
module mno_line_store
  import mno_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             step_vld,
  input  logic [COL_W-1:0] step_col,
  input  logic             step_par,
  input  step_meta_t       step_meta,
  input  logic [7:0]       pix_mask,
  input  logic [23:0]      pix_colour,
  output logic             s2_vld,
  output step_meta_t       s2_meta,
  output logic [8:0][7:0]  win,
  output logic [23:0]      ctr_colour
);

  // Even and odd rows of masks, and one row of colours
  logic [7:0]  even_mem [LINE_DEPTH];
  logic [7:0]  odd_mem  [LINE_DEPTH];
  logic [23:0] col_mem  [LINE_DEPTH];

  logic [7:0]  even_rd_r;
  logic [7:0]  odd_rd_r;
  logic [23:0] col_rd_r;

  logic        s1_vld_r;
  step_meta_t  s1_meta_r;
  logic [7:0]  s1_mask_r;
  logic        s1_par_r;

  logic        s2_vld_r;
  step_meta_t  s2_meta_r;
  logic [2:0][7:0] top_r;
  logic [2:0][7:0] mid_r;
  logic [2:0][7:0] bot_r;
  logic [23:0] c2_r;
  logic [23:0] c3_r;

  logic        step_go;
  logic [7:0]  v_top;
  logic [7:0]  v_mid;

  assign step_go = advance & step_vld;

  // Read old contents and write this step's row at the same column
  always_ff @(posedge clk) begin
    if (step_go) begin
      even_rd_r <= even_mem[step_col];
      if (!step_par) begin
        even_mem[step_col] <= pix_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      odd_rd_r <= odd_mem[step_col];
      if (step_par) begin
        odd_mem[step_col] <= pix_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      col_rd_r           <= col_mem[step_col];
      col_mem[step_col]  <= pix_colour;
    end
  end

  // Stage 1: step control alongside the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= step_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_meta_r <= step_meta;
      s1_mask_r <= pix_mask;
      s1_par_r  <= step_par;
    end
  end

  // Row two above shares the parity of the current row
  assign v_top = s1_par_r ? odd_rd_r  : even_rd_r;
  assign v_mid = s1_par_r ? even_rd_r : odd_rd_r;

  // Stage 2: shift the new column into the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_meta_r <= s1_meta_r;
      if (s1_vld_r) begin
        top_r <= {v_top, top_r[2], top_r[1]};
        mid_r <= {v_mid, mid_r[2], mid_r[1]};
        bot_r <= {s1_mask_r, bot_r[2], bot_r[1]};
        c2_r  <= col_rd_r;
        c3_r  <= c2_r;
      end
    end
  end

  assign s2_vld     = s2_vld_r;
  assign s2_meta    = s2_meta_r;
  assign win        = {bot_r[2], bot_r[1], bot_r[0],
                       mid_r[2], mid_r[1], mid_r[0],
                       top_r[2], top_r[1], top_r[0]};
  assign ctr_colour = c3_r;

endmodule

/* sv/mno_decide.sv */
// Neighbour closeness test, count and colour selection for one result.
// Depends on mno_pkg; takes the window from mno_line_store.
module mno_decide
  import mno_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            s2_vld,
  input  step_meta_t      s2_meta,
  input  logic [8:0][7:0] win,
  input  logic [23:0]     ctr_colour,
  input  logic [7:0]      close_limit,
  input  logic [3:0]      nb_min,
  input  logic [23:0]     mark_colour,
  output logic            up_vld,
  output result_t         up_res
);

  logic        s3_vld_r;
  step_meta_t  s3_meta_r;
  logic [8:0]  s3_close_r;
  logic        s3_zero_r;
  logic [23:0] s3_colour_r;

  logic [8:0]  close_nxt;
  logic [3:0]  count;
  logic        marked;

  // Flag each in-image neighbour whose mask lies within the limit
  always_comb begin
    logic ok;
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        ok = 1'b1;
        if (rr == 0) ok = ok & s2_meta.top_ok;
        if (rr == 2) ok = ok & s2_meta.bot_ok;
        if (cc == 0) ok = ok & s2_meta.left_ok;
        if (cc == 2) ok = ok & s2_meta.right_ok;
        if (rr == 1 && cc == 1) ok = 1'b0;
        close_nxt[rr*3+cc] = ok & (win[rr*3+cc] <= close_limit);
      end
    end
  end

  // Stage 3: closeness flags and centre test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (advance) begin
      s3_vld_r <= s2_vld & s2_meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_meta_r   <= s2_meta;
      s3_close_r  <= close_nxt;
      s3_zero_r   <= (win[4] == 8'd0);
      s3_colour_r <= ctr_colour;
    end
  end

  // Count close neighbours and pick the colour
  assign count  = count_ones9(s3_close_r);
  assign marked = s3_zero_r & (count >= nb_min);

  assign up_vld       = advance & s3_vld_r;
  assign up_res.blue  = marked ? mark_colour[7:0]   : s3_colour_r[7:0];
  assign up_res.green = marked ? mark_colour[15:8]  : s3_colour_r[15:8];
  assign up_res.red   = marked ? mark_colour[23:16] : s3_colour_r[23:16];
  assign up_res.marked = marked;
  assign up_res.fend   = s3_meta_r.fend;

endmodule

/* sv/mno_out_buf.sv */
// Output register with a one-entry skid stage for the result channel.
// Depends on mno_pkg; the skid flag holds the whole pipeline.
module mno_out_buf
  import mno_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_vld,
  input  result_t up_res,
  input  logic    out_stall,
  output logic    out_vld,
  output result_t out_res,
  output logic    skid_full
);

  logic    out_vld_r;
  result_t out_res_r;
  logic    skid_vld_r;
  result_t skid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_stall) begin
      // Transfer done: refill from the skid stage first
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else if (!up_vld) begin
        out_vld_r <= 1'b0;
      end
    end else if (!out_vld_r) begin
      if (up_vld) begin
        out_vld_r <= 1'b1;
      end
    end else if (up_vld) begin
      // Output stalled: park the new result
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_stall) begin
      if (skid_vld_r) begin
        out_res_r <= skid_res_r;
      end else if (up_vld) begin
        out_res_r <= up_res;
      end
    end else if (!out_vld_r) begin
      if (up_vld) begin
        out_res_r <= up_res;
      end
    end else if (up_vld) begin
      skid_res_r <= up_res;
    end
  end

  assign out_vld   = out_vld_r;
  assign out_res   = out_res_r;
  assign skid_full = skid_vld_r;

endmodule

/* sv/mask_neighbor_overlay_unit.sv */
// Top level of the mask neighbour overlay unit: configuration registers and wiring.
// Depends on mno_pkg, mno_front, mno_line_store, mno_decide and mno_out_buf.

// Takes one raster-order item per clock and gives one result per clock once the
// stream is primed; each pixel's result leaves one row plus one pixel behind
// it, and after the frame's last pixel one flush item (or pixel item, which is
// then dropped) must be sent for each pending result. The line memories are
// read and written once per item at a single column address, so throughput is
// one item a cycle; after the last pixel of a single-row frame the input is
// stalled while one spare step is injected. The input is also held while a
// result stalled on the output fills the one-entry skid stage. After the transfer
// that releases it, a result passes through three register stages and then the
// output register before it is offered. No clearing pass runs after reset;
// writing image_width or image_height drops any frame in progress.
module mask_neighbor_overlay_unit
  import mno_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [7:0]            in_mask_value,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  output logic                  out_was_marked,
  output logic                  out_frame_end
);

  logic [COL_W-1:0] width_last_r;
  logic [ROW_W-1:0] height_last_r;
  logic [7:0]       close_limit_r;
  logic [3:0]       nb_min_r;
  logic [7:0]       mark_blue_r;
  logic [7:0]       mark_green_r;
  logic [7:0]       mark_red_r;

  logic             size_wr;
  logic             advance;
  logic             skid_full;
  logic             step_vld;
  logic [COL_W-1:0] step_col;
  logic             step_par;
  step_meta_t       step_meta;
  logic             s2_vld;
  step_meta_t       s2_meta;
  logic [8:0][7:0]  win;
  logic [23:0]      ctr_colour;
  logic             up_vld;
  result_t          up_res;
  result_t          out_res;

  // Configuration registers; frame sizes are kept as last index, clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= COL_W'(RST_IMAGE_WIDTH - 1);
      height_last_r <= ROW_W'(RST_IMAGE_HEIGHT - 1);
      close_limit_r <= RST_CLOSE_LIMIT;
      nb_min_r      <= RST_NEIGHBOR_MINIMUM;
      mark_blue_r   <= RST_MARK_BLUE;
      mark_green_r  <= RST_MARK_GREEN;
      mark_red_r    <= RST_MARK_RED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:      width_last_r  <= width_last(cfg_data);
        REG_IMAGE_HEIGHT:     height_last_r <= height_last(cfg_data);
        REG_CLOSE_LIMIT:      close_limit_r <= cfg_data[7:0];
        REG_NEIGHBOR_MINIMUM: nb_min_r      <= cfg_data[3:0];
        REG_MARK_BLUE:        mark_blue_r   <= cfg_data[7:0];
        REG_MARK_GREEN:       mark_green_r  <= cfg_data[7:0];
        REG_MARK_RED:         mark_red_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign size_wr = cfg_we &&
                   ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  // Whole pipeline moves while the skid stage is empty
  assign advance = ~skid_full;

  mno_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .width_last  (width_last_r),
    .height_last (height_last_r),
    .size_wr     (size_wr),
    .step_vld    (step_vld),
    .step_col    (step_col),
    .step_par    (step_par),
    .step_meta   (step_meta)
  );

  mno_line_store u_line_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .step_vld   (step_vld),
    .step_col   (step_col),
    .step_par   (step_par),
    .step_meta  (step_meta),
    .pix_mask   (in_mask_value),
    .pix_colour ({in_red, in_green, in_blue}),
    .s2_vld     (s2_vld),
    .s2_meta    (s2_meta),
    .win        (win),
    .ctr_colour (ctr_colour)
  );

  mno_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .s2_vld      (s2_vld),
    .s2_meta     (s2_meta),
    .win         (win),
    .ctr_colour  (ctr_colour),
    .close_limit (close_limit_r),
    .nb_min      (nb_min_r),
    .mark_colour ({mark_red_r, mark_green_r, mark_blue_r}),
    .up_vld      (up_vld),
    .up_res      (up_res)
  );

  mno_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (up_vld),
    .up_res    (up_res),
    .out_stall (out_stall),
    .out_vld   (out_valid),
    .out_res   (out_res),
    .skid_full (skid_full)
  );

  assign out_blue       = out_res.blue;
  assign out_green      = out_res.green;
  assign out_red        = out_res.red;
  assign out_was_marked = out_res.marked;
  assign out_frame_end  = out_res.fend;

endmodule
